[rtl/mask_coverage_src_over_blend_defines.svh]
// Assertion macros for the mask coverage blender checker.
`ifndef MASK_COVERAGE_SRC_OVER_BLEND_DEFINES_SVH
`define MASK_COVERAGE_SRC_OVER_BLEND_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define MCB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define MCB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/mcb_pkg.sv]
// Shared types, constants and helpers of the mask coverage blender.
`timescale 1ns / 1ps

package mcb_pkg;
	localparam int ColorW = 8;
	localparam int PixW = 32;
	localparam int ProdW = 2 * ColorW;
	localparam int NumW = ProdW + 1;
	localparam int QuoW = ColorW;
	localparam int InW = ColorW + PixW;
	localparam int FrontStages = 5;
	localparam int DivStepDefault = 2;
	localparam int RegIdxW = 2;

	localparam logic [RegIdxW-1:0] RegRed = 2'd0;
	localparam logic [RegIdxW-1:0] RegGreen = 2'd1;
	localparam logic [RegIdxW-1:0] RegBlue = 2'd2;
	localparam logic [RegIdxW-1:0] RegAlpha = 2'd3;

	localparam logic [ColorW-1:0] FullAlpha = 8'hFF;
	localparam logic [ProdW-1:0] RoundHalf = 16'd127;

	typedef enum logic [1:0] {
		ModeKeep,
		ModeFill,
		ModeBlend,
		ModeZero
	} mode_t;

	typedef struct packed {
		logic [ColorW-1:0] red;
		logic [ColorW-1:0] green;
		logic [ColorW-1:0] blue;
		logic [ColorW-1:0] alpha;
	} color_t;

	// rem and quo lanes: 2 red, 1 green, 0 blue
	typedef struct packed {
		mode_t mode;
		logic [PixW-1:0] bypass;
		logic [ColorW-1:0] den;
		logic [2:0][NumW-1:0] rem;
		logic [2:0][QuoW-1:0] quo;
	} div_t;

	// exact x / 255 for x below 65280
	function automatic logic [ColorW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW:0] s;
		s = {1'b0, x} + {{(ColorW + 1){1'b0}}, x[ProdW-1:ColorW]} + {{ProdW{1'b0}}, 1'b1};
		return s[ProdW-1:ColorW];
	endfunction
endpackage

[rtl/mcb_cfg.sv]
// Source color registers of the mask coverage blender.
`timescale 1ns / 1ps

module mcb_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mcb_pkg::RegIdxW-1:0]       wr_index,
	input  logic [mcb_pkg::ColorW-1:0]        wr_data,
	output mcb_pkg::color_t                   color
);
	mcb_pkg::color_t color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q.red <= '0;
			color_q.green <= '0;
			color_q.blue <= '0;
			color_q.alpha <= mcb_pkg::FullAlpha;
		end else if (wr_en) begin
			unique case (wr_index)
				mcb_pkg::RegRed: color_q.red <= wr_data;
				mcb_pkg::RegGreen: color_q.green <= wr_data;
				mcb_pkg::RegBlue: color_q.blue <= wr_data;
				mcb_pkg::RegAlpha: color_q.alpha <= wr_data;
			endcase
		end
	end

	assign color = color_q;
endmodule

[rtl/mcb_front.sv]
// Alpha, weight and numerator stages of the mask coverage blender.
`timescale 1ns / 1ps

module mcb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mcb_pkg::ColorW-1:0]    coverage,
	input  logic [mcb_pkg::PixW-1:0]      dest_pixel,
	input  mcb_pkg::color_t               color,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mcb_pkg::div_t                 out_item
);
	localparam int CW = mcb_pkg::ColorW;
	localparam int PW = mcb_pkg::ProdW;
	localparam int NW = mcb_pkg::NumW;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [PW-1:0] prod_s1;
	logic [mcb_pkg::PixW-1:0] dst_s1, dst_s2, dst_s3, dst_s4;
	logic [CW-1:0] sa_s2, sa_s3, sa_s4;
	logic [PW-1:0] wprod_s3;
	logic [2:0][PW-1:0] csa_s3, csa_s4;
	logic [CW-1:0] w_s4;
	mcb_pkg::div_t item_s5;

	logic [CW:0] oa;
	logic [2:0][NW-1:0] num;
	mcb_pkg::div_t item_d;

	assign rdy5 = !valid_s5 || out_ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	always_comb begin
		oa = {1'b0, sa_s4} + {1'b0, w_s4};
		num[2] = {1'b0, csa_s4[2]} + NW'(PW'(dst_s4[23:16]) * PW'(w_s4));
		num[1] = {1'b0, csa_s4[1]} + NW'(PW'(dst_s4[15:8]) * PW'(w_s4));
		num[0] = {1'b0, csa_s4[0]} + NW'(PW'(dst_s4[7:0]) * PW'(w_s4));
		item_d.den = oa[CW-1:0];
		item_d.rem = num;
		item_d.quo = '0;
		priority if (sa_s4 == '0) begin
			item_d.mode = mcb_pkg::ModeKeep;
			item_d.bypass = dst_s4;
		end else if (sa_s4 == mcb_pkg::FullAlpha) begin
			item_d.mode = mcb_pkg::ModeFill;
			item_d.bypass = {mcb_pkg::FullAlpha, color.red, color.green, color.blue};
		end else if (oa == '0) begin
			item_d.mode = mcb_pkg::ModeZero;
			item_d.bypass = '0;
		end else begin
			item_d.mode = mcb_pkg::ModeBlend;
			item_d.bypass = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			prod_s1 <= PW'(coverage) * PW'(color.alpha);
			dst_s1 <= dest_pixel;
		end
		if (rdy2 && valid_s1) begin
			sa_s2 <= mcb_pkg::div255(prod_s1 + mcb_pkg::RoundHalf);
			dst_s2 <= dst_s1;
		end
		if (rdy3 && valid_s2) begin
			wprod_s3 <= PW'(dst_s2[31:24]) * PW'(mcb_pkg::FullAlpha - sa_s2);
			csa_s3[2] <= PW'(color.red) * PW'(sa_s2);
			csa_s3[1] <= PW'(color.green) * PW'(sa_s2);
			csa_s3[0] <= PW'(color.blue) * PW'(sa_s2);
			sa_s3 <= sa_s2;
			dst_s3 <= dst_s2;
		end
		if (rdy4 && valid_s3) begin
			w_s4 <= mcb_pkg::div255(wprod_s3);
			csa_s4 <= csa_s3;
			sa_s4 <= sa_s3;
			dst_s4 <= dst_s3;
		end
		if (rdy5 && valid_s4) begin
			item_s5 <= item_d;
		end
	end

	assign out_valid = valid_s5;
	assign out_item = item_s5;
endmodule

[rtl/mcb_div.sv]
// Pipelined restoring divider for the three color channels.
`timescale 1ns / 1ps

module mcb_div #(
	parameter int DivStep = mcb_pkg::DivStepDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mcb_pkg::div_t in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output mcb_pkg::div_t out_item
);
	localparam int Stages = mcb_pkg::QuoW / DivStep;
	localparam int NW = mcb_pkg::NumW;
	localparam int QW = mcb_pkg::QuoW;

	function automatic mcb_pkg::div_t div_step(input mcb_pkg::div_t d, input int k);
		mcb_pkg::div_t r;
		logic [NW-1:0] trial;
		int b;
		r = d;
		for (int j = 0; j < DivStep; j++) begin
			b = QW - 1 - k * DivStep - j;
			trial = NW'(d.den) << b;
			for (int ch = 0; ch < 3; ch++) begin
				if (r.rem[ch] >= trial) begin
					r.rem[ch] = r.rem[ch] - trial;
					r.quo[ch] = r.quo[ch] | (QW'(1) << b);
				end
			end
		end
		return r;
	endfunction

	mcb_pkg::div_t item_s [Stages];
	logic valid_s [Stages];
	mcb_pkg::div_t src [Stages + 1];
	logic vsrc [Stages + 1];
	logic rdy [Stages + 1];

	assign src[0] = in_item;
	assign vsrc[0] = in_valid;
	assign rdy[Stages] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < Stages; k++) begin : g_stage
		assign src[k + 1] = item_s[k];
		assign vsrc[k + 1] = valid_s[k];
		assign rdy[k] = !valid_s[k] || rdy[k + 1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= vsrc[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vsrc[k]) begin
				item_s[k] <= div_step(src[k], k);
			end
		end
	end

	assign out_valid = vsrc[Stages];
	assign out_item = src[Stages];
endmodule

[rtl/mask_coverage_src_over_blend.sv]
// Top level of the solid color coverage mask source-over blender.
//
// channel  direction  handshake           payload
// s_*      in         s_tvalid/s_tready   coverage, dest_pixel
// m_*      out        m_tvalid/m_tready   out_pixel
// wr_*     in         wr_en               wr_index, wr_data
//
// One pixel enters per cycle while s_tready is high. The path holds
// five arithmetic stages, the divider at DivStep quotient bits a stage, one output register.
// Reset clears all valid bits and loads the color registers; no clearing pass.
// A stall at m_tready fills empty stages first; s_tready drops only when every stage holds an item.
`timescale 1ns / 1ps

module mask_coverage_src_over_blend #(
	parameter int DivStep = mcb_pkg::DivStepDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mcb_pkg::InW-1:0]        s_tdata,   // coverage[7:0], dest_pixel[39:8]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mcb_pkg::PixW-1:0]       m_tdata,   // out_pixel[31:0]
	input  logic                           wr_en,
	input  logic [mcb_pkg::RegIdxW-1:0]    wr_index,
	input  logic [mcb_pkg::ColorW-1:0]     wr_data
);
	mcb_pkg::color_t color;
	logic front_valid, front_ready;
	mcb_pkg::div_t front_item;
	logic div_valid, div_ready;
	mcb_pkg::div_t div_item;

	logic out_valid_q;
	logic [mcb_pkg::PixW-1:0] pixel_q;
	logic [mcb_pkg::PixW-1:0] pixel_d;

	mcb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.color    (color)
	);

	mcb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.coverage   (s_tdata[mcb_pkg::ColorW-1:0]),
		.dest_pixel (s_tdata[mcb_pkg::InW-1:mcb_pkg::ColorW]),
		.color      (color),
		.out_valid  (front_valid),
		.out_ready  (front_ready),
		.out_item   (front_item)
	);

	mcb_div #(
		.DivStep (DivStep)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_item  (div_item)
	);

	assign div_ready = !out_valid_q || m_tready;

	always_comb begin
		unique case (div_item.mode)
			mcb_pkg::ModeBlend: pixel_d = {div_item.den, div_item.quo[2], div_item.quo[1],
				div_item.quo[0]};
			mcb_pkg::ModeKeep, mcb_pkg::ModeFill, mcb_pkg::ModeZero: pixel_d = div_item.bypass;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ready) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready && div_valid) begin
			pixel_q <= pixel_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = pixel_q;
endmodule

[rtl/mcb_checker.sv]
// Port-level checker of the mask coverage blender and its bind.
`timescale 1ns / 1ps
`include "mask_coverage_src_over_blend_defines.svh"

module mcb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mcb_pkg::PixW-1:0]   m_tdata
);
	localparam int MaxDepth = mcb_pkg::FrontStages + mcb_pkg::QuoW + 1;
	localparam int CntW = $clog2(MaxDepth + 1);

	logic [CntW-1:0] cnt_q;
	logic in_acc, out_acc;

	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CntW'(in_acc) - CntW'(out_acc);
		end
	end

	`MCB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`MCB_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
	`MCB_ASSERT_NOW(a_no_invented, m_tvalid, cnt_q != '0)
	`MCB_ASSERT_NOW(a_bounded, 1'b1, cnt_q <= CntW'(MaxDepth))
endmodule

bind mask_coverage_src_over_blend mcb_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/mask_coverage_src_over_blend_test.sv]
// Self-checking testbench for the mask coverage source-over blender.
`timescale 1ns / 1ps

module mask_coverage_src_over_blend_test;
	localparam int ColorW = mcb_pkg::ColorW;
	localparam int PixW = mcb_pkg::PixW;
	localparam int ProdW = mcb_pkg::ProdW;
	localparam int NumW = mcb_pkg::NumW;
	localparam int InW = mcb_pkg::InW;
	localparam int RegIdxW = mcb_pkg::RegIdxW;

	localparam int CycleLimit = 200000;
	localparam int SettleCycles = 40;
	localparam int NumPhases = 12;
	localparam int PhaseItems = 160;

	typedef enum logic [1:0] {
		JobPixel,
		JobWrite,
		JobDrain
	} job_kind_t;

	typedef struct {
		job_kind_t kind;
		logic [ColorW-1:0] coverage;
		logic [PixW-1:0] dest_pixel;
		logic [RegIdxW-1:0] reg_index;
		logic [ColorW-1:0] reg_value;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [PixW-1:0] m_tdata;
	logic wr_en = 1'b0;
	logic [RegIdxW-1:0] wr_index = '0;
	logic [ColorW-1:0] wr_data = '0;

	job_t pixel_jobs[$];
	logic [PixW-1:0] expected_pixels[$];
	logic [ColorW-1:0] src_red, src_green, src_blue, src_alpha;
	logic in_taken = 1'b0;
	logic steady = 1'b0;
	int sent_count = 0;
	int cycle_count = 0;
	int error_count = 0;

	mask_coverage_src_over_blend u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	function automatic logic [PixW-1:0] blend_pixel(input logic [ColorW-1:0] coverage,
			input logic [PixW-1:0] dest_pixel);
		logic [ProdW-1:0] prod;
		logic [ColorW-1:0] sa, da, w;
		logic [ColorW:0] oa;
		logic [NumW-1:0] num_r, num_g, num_b;
		logic [ColorW-1:0] out_r, out_g, out_b;
		prod = ProdW'(coverage) * ProdW'(src_alpha);
		sa = ColorW'((prod + mcb_pkg::RoundHalf) / ProdW'(mcb_pkg::FullAlpha));
		if (sa == '0)
			return dest_pixel;
		if (sa == mcb_pkg::FullAlpha)
			return {mcb_pkg::FullAlpha, src_red, src_green, src_blue};
		da = dest_pixel[31:24];
		prod = ProdW'(da) * ProdW'(mcb_pkg::FullAlpha - sa);
		w = ColorW'(prod / ProdW'(mcb_pkg::FullAlpha));
		oa = {1'b0, sa} + {1'b0, w};
		if (oa == '0)
			return '0;
		num_r = NumW'(ProdW'(src_red) * ProdW'(sa)) +
			NumW'(ProdW'(dest_pixel[23:16]) * ProdW'(w));
		num_g = NumW'(ProdW'(src_green) * ProdW'(sa)) +
			NumW'(ProdW'(dest_pixel[15:8]) * ProdW'(w));
		num_b = NumW'(ProdW'(src_blue) * ProdW'(sa)) +
			NumW'(ProdW'(dest_pixel[7:0]) * ProdW'(w));
		out_r = ColorW'(num_r / NumW'(oa));
		out_g = ColorW'(num_g / NumW'(oa));
		out_b = ColorW'(num_b / NumW'(oa));
		return {oa[ColorW-1:0], out_r, out_g, out_b};
	endfunction

	task automatic report_error(input string what, input logic [PixW-1:0] got,
			input logic [PixW-1:0] want);
		error_count++;
		$display("ERROR at %0t: %s: got %08h, want %08h", $time, what, got, want);
	endtask

	task automatic add_pixel(input logic [ColorW-1:0] coverage, input logic [PixW-1:0] dest_pixel);
		job_t j;
		j = '{JobPixel, coverage, dest_pixel, '0, '0};
		pixel_jobs.push_back(j);
	endtask

	task automatic add_write(input logic [RegIdxW-1:0] idx, input logic [ColorW-1:0] value);
		job_t j;
		j = '{JobWrite, '0, '0, idx, value};
		pixel_jobs.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j = '{JobDrain, '0, '0, '0, '0};
		pixel_jobs.push_back(j);
	endtask

	function automatic logic [ColorW-1:0] pick_color();
		case ($urandom_range(3))
			0: return '0;
			1: return mcb_pkg::FullAlpha;
			default: return ColorW'($urandom);
		endcase
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin : drive_input
		logic nv;
		logic [InW-1:0] nd;
		logic ne;
		logic [RegIdxW-1:0] ni;
		logic [ColorW-1:0] nw;
		nv = s_tvalid;
		nd = s_tdata;
		ne = 1'b0;
		ni = wr_index;
		nw = wr_data;
		if (!arst_n) begin
			nv = 1'b0;
		end else begin
			if (s_tvalid && in_taken)
				nv = 1'b0;
			if (!nv && pixel_jobs.size() > 0) begin
				case (pixel_jobs[0].kind)
					JobWrite: begin
						if (expected_pixels.size() == 0) begin
							ne = 1'b1;
							ni = pixel_jobs[0].reg_index;
							nw = pixel_jobs[0].reg_value;
							void'(pixel_jobs.pop_front());
						end
					end
					JobDrain: begin
						if (expected_pixels.size() == 0)
							void'(pixel_jobs.pop_front());
					end
					default: begin
						if (steady || $urandom_range(99) >= 30) begin
							nv = 1'b1;
							nd = {pixel_jobs[0].dest_pixel, pixel_jobs[0].coverage};
							void'(pixel_jobs.pop_front());
							sent_count++;
							steady = (sent_count >= 800 && sent_count < 1100);
						end
					end
				endcase
			end
		end
		s_tvalid <= nv;
		s_tdata <= nd;
		wr_en <= ne;
		wr_index <= ni;
		wr_data <= nw;
	end

	always @(negedge clk) begin
		m_tready <= !arst_n || steady || $urandom_range(99) >= 30;
	end

	always @(posedge clk) begin : watch_ports
		logic [PixW-1:0] want;
		cycle_count++;
		in_taken = arst_n && s_tvalid && s_tready;
		if (!arst_n) begin
			src_red = '0;
			src_green = '0;
			src_blue = '0;
			src_alpha = mcb_pkg::FullAlpha;
		end else begin
			if (wr_en) begin
				case (wr_index)
					mcb_pkg::RegRed: src_red = wr_data;
					mcb_pkg::RegGreen: src_green = wr_data;
					mcb_pkg::RegBlue: src_blue = wr_data;
					mcb_pkg::RegAlpha: src_alpha = wr_data;
					default: ;
				endcase
			end
			if (in_taken)
				expected_pixels.push_back(blend_pixel(s_tdata[7:0], s_tdata[39:8]));
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					report_error("out_pixel with no item pending", m_tdata, '0);
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want)
						report_error("out_pixel mismatch", m_tdata, want);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [ColorW-1:0] cov;
		logic [PixW-1:0] dst;
		// reset colors: black, opaque
		add_pixel(8'h00, 32'hA5C3_7E19);
		add_pixel(8'hFF, 32'hFFFF_FFFF);
		add_pixel(8'h01, 32'hFFFF_FFFF);
		add_pixel(8'h80, 32'h0000_0000);
		add_pixel(8'hFE, 32'h80FF_00FF);
		add_write(mcb_pkg::RegRed, 8'hFF);
		add_write(mcb_pkg::RegGreen, 8'h80);
		add_write(mcb_pkg::RegBlue, 8'h01);
		add_write(mcb_pkg::RegAlpha, 8'hFF);
		add_pixel(8'hFF, 32'h1234_5678);
		add_pixel(8'h80, 32'hFF00_0000);
		add_pixel(8'h40, 32'h7F7F_7F7F);
		add_pixel(8'h01, 32'h00FF_FFFF);
		add_pixel(8'hC8, 32'hFFFF_FFFF);
		// zero source alpha leaves the destination alone
		add_write(mcb_pkg::RegAlpha, 8'h00);
		add_pixel(8'hFF, 32'h89AB_CDEF);
		add_pixel(8'h00, 32'h0000_0000);
		add_write(mcb_pkg::RegAlpha, 8'h01);
		add_write(mcb_pkg::RegRed, 8'h00);
		add_write(mcb_pkg::RegGreen, 8'hFF);
		add_write(mcb_pkg::RegBlue, 8'hFF);
		add_pixel(8'hFF, 32'hFFFF_FFFF);
		add_pixel(8'h7F, 32'h0000_0000);
		add_pixel(8'h80, 32'h8080_8080);
		add_write(mcb_pkg::RegAlpha, 8'h80);
		add_pixel(8'hFF, 32'h40C0_C0C0);
		add_pixel(8'h02, 32'hFFFF_FFFF);
		add_drain();

		for (int p = 0; p < NumPhases; p++) begin
			if (p == 0) begin
				add_write(mcb_pkg::RegRed, 8'h00);
				add_write(mcb_pkg::RegGreen, 8'hFF);
				add_write(mcb_pkg::RegBlue, 8'h00);
				add_write(mcb_pkg::RegAlpha, 8'hFF);
			end else if (p == NumPhases - 1) begin
				add_write(mcb_pkg::RegRed, 8'hFF);
				add_write(mcb_pkg::RegGreen, 8'h00);
				add_write(mcb_pkg::RegBlue, 8'hFF);
				add_write(mcb_pkg::RegAlpha, 8'h00);
			end else begin
				add_write(mcb_pkg::RegRed, pick_color());
				add_write(mcb_pkg::RegGreen, pick_color());
				add_write(mcb_pkg::RegBlue, pick_color());
				add_write(mcb_pkg::RegAlpha, pick_color());
			end
			for (int i = 0; i < PhaseItems; i++) begin
				case ($urandom_range(9))
					0: cov = '0;
					1: cov = 8'hFF;
					2: cov = ColorW'($urandom_range(3));
					default: cov = ColorW'($urandom);
				endcase
				dst = $urandom;
				case ($urandom_range(7))
					0: dst[31:24] = 8'h00;
					1: dst[31:24] = 8'hFF;
					default: ;
				endcase
				add_pixel(cov, dst);
				if (i == PhaseItems / 2)
					add_drain();
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pixel_jobs.size() > 0 || s_tvalid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (error_count == 0 && expected_pixels.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
